FILE: rtl/lesf_pkg.sv
// ----------------------------------------------------------------------------
// lesf_pkg: shared definitions for the largest empty square finder
// Map size limits, field widths, register indexes and the size clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package lesf_pkg;

  // Largest map the line buffer and counters support.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Column and row counters index the map.
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // Map dimension registers and square sizes.
  localparam int DIM_W  = 11;
  localparam int SIZE_W = 11;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } cfg_reg_t;

  // Zero is treated as one, anything above the maximum as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    begin
      if (v == '0) begin
        r = DIM_W'(1);
      end else if (v > maxv) begin
        r = maxv;
      end else begin
        r = v;
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lesf_ram.sv
// ----------------------------------------------------------------------------
// lesf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read returns old data on a
// same-address collision.
// ----------------------------------------------------------------------------
`default_nettype none

module lesf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/largest_empty_square_finder.sv
// ----------------------------------------------------------------------------
// largest_empty_square_finder: maximal empty square over a streamed bitmap
// Takes one map cell per transaction in row-major order and reports the size
// and bottom-right corner of the largest empty square at the end of the map.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake              Payload
// -------  ---------  ---------------------  ----------------------------------
// in       sink       in_valid / in_stall    cell_free
// out      source     out_valid / out_stall  square_size, bottom_row, bottom_col
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One cell is taken every clock unless in_stall is high; its value is computed
// in the cycle it is accepted, from the previous-row RAM word read ahead of it.
// The result appears on the output register in the cycle after the last cell.
// Input stalls only when a result is held on a stalled output and the next
// cell would end the map. Reset clears the scan position, best and output valid.
// The line buffer is not cleared; row 0 writes every entry below the map width.
//
`default_nettype none

module largest_empty_square_finder (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Cell input
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              cell_free,
  // Result output
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [lesf_pkg::SIZE_W-1:0]            square_size,
  output logic [lesf_pkg::ROW_W-1:0]             bottom_row,
  output logic [lesf_pkg::COL_W-1:0]             bottom_col,
  // Configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lesf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lesf_pkg::DIM_W-1:0]        cfg_data
);

  localparam int COL_W  = lesf_pkg::COL_W;
  localparam int ROW_W  = lesf_pkg::ROW_W;
  localparam int DIM_W  = lesf_pkg::DIM_W;
  localparam int SIZE_W = lesf_pkg::SIZE_W;

  // Registers
  logic [DIM_W-1:0]  map_width;
  logic [DIM_W-1:0]  map_height;
  logic [SIZE_W-1:0] left_value;
  logic [SIZE_W-1:0] diag_value;
  logic [COL_W-1:0]  col_count;
  logic [ROW_W-1:0]  row_count;
  logic [SIZE_W-1:0] best_size;
  logic [ROW_W-1:0]  best_row;
  logic [COL_W-1:0]  best_col;
  logic              fwd_hit;
  logic [SIZE_W-1:0] fwd_data;

  // Next values and datapath
  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic              in_acc;
  logic              row_end;
  logic              map_end;
  logic              last_cell;
  logic [SIZE_W-1:0] up_value;
  logic [SIZE_W-1:0] min_value;
  logic [SIZE_W-1:0] cell_value;
  logic              new_best;
  logic [SIZE_W-1:0] best_size_next;
  logic [ROW_W-1:0]  best_row_next;
  logic [COL_W-1:0]  best_col_next;
  logic [COL_W-1:0]  col_count_next;
  logic [ROW_W-1:0]  row_count_next;
  logic [SIZE_W-1:0] left_value_next;
  logic [SIZE_W-1:0] diag_value_next;
  logic [COL_W-1:0]  rd_addr;
  logic [SIZE_W-1:0] ram_rdata;

  // Configuration port is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= DIM_W'(1);
      map_height <= DIM_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == lesf_pkg::REG_MAP_WIDTH) begin
        map_width <= cfg_data;
      end else if (cfg_index == lesf_pkg::REG_MAP_HEIGHT) begin
        map_height <= cfg_data;
      end
    end
  end

  // Effective map size and end-of-row / end-of-map detection.
  assign w_eff = lesf_pkg::clamp_dim(map_width, DIM_W'(lesf_pkg::MAX_WIDTH));
  assign h_eff = lesf_pkg::clamp_dim(map_height, DIM_W'(lesf_pkg::MAX_HEIGHT));

  assign row_end   = (DIM_W'(col_count) + DIM_W'(1)) >= w_eff;
  assign map_end   = (DIM_W'(row_count) + DIM_W'(1)) >= h_eff;
  assign last_cell = row_end && map_end;

  // Input stalls only if the next cell would produce a result that cannot land.
  assign in_stall = out_valid && out_stall && last_cell;
  assign in_acc   = in_valid && !in_stall;

  // Previous-row value, forwarded when it was written in the last cycle.
  assign up_value = fwd_hit ? fwd_data : ram_rdata;

  // Three-way minimum and cell value.
  always_comb begin
    min_value = left_value;
    if (up_value < min_value) begin
      min_value = up_value;
    end
    if (diag_value < min_value) begin
      min_value = diag_value;
    end
    if (!cell_free) begin
      cell_value = '0;
    end else if (row_count == '0 || col_count == '0) begin
      cell_value = SIZE_W'(1);
    end else begin
      cell_value = min_value + SIZE_W'(1);
    end
  end

  // Running best; first corner in scan order wins on ties.
  assign new_best       = cell_value > best_size;
  assign best_size_next = new_best ? cell_value : best_size;
  assign best_row_next  = new_best ? row_count : best_row;
  assign best_col_next  = new_best ? col_count : best_col;

  // Scan position and neighbor values for the next cell.
  always_comb begin
    col_count_next  = col_count + COL_W'(1);
    row_count_next  = row_count;
    left_value_next = cell_value;
    diag_value_next = up_value;
    if (row_end) begin
      col_count_next  = '0;
      left_value_next = '0;
      diag_value_next = '0;
      row_count_next  = map_end ? '0 : row_count + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      left_value <= '0;
      diag_value <= '0;
      best_size  <= '0;
      best_row   <= '0;
      best_col   <= '0;
    end else if (in_acc) begin
      col_count  <= col_count_next;
      row_count  <= row_count_next;
      left_value <= left_value_next;
      diag_value <= diag_value_next;
      if (last_cell) begin
        best_size <= '0;
        best_row  <= '0;
        best_col  <= '0;
      end else begin
        best_size <= best_size_next;
        best_row  <= best_row_next;
        best_col  <= best_col_next;
      end
    end
  end

  // Line buffer: prefetch the column of the next cell to be processed.
  assign rd_addr = in_acc ? col_count_next : col_count;

  lesf_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (lesf_pkg::MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (in_acc),
    .waddr (col_count),
    .wdata (cell_value),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Bypass for a read of the column written in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= in_acc && (rd_addr == col_count);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= cell_value;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && last_cell) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last_cell) begin
      square_size <= best_size_next;
      bottom_row  <= best_row_next;
      bottom_col  <= best_col_next;
    end
  end

`ifndef SYNTHESIS
  // A transaction on the last cell always leaves a result behind.
  a_result_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_acc && last_cell) |=> out_valid)
    else $error("no result after the last cell of a map");

  // An empty result reports the origin as its corner.
  a_zero_at_origin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && square_size == '0) |-> (bottom_row == '0 && bottom_col == '0))
    else $error("size zero result with nonzero corner");

  // The bypass only follows a write in the previous cycle.
  a_fwd_after_write: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> $past(in_acc))
    else $error("line buffer bypass without a preceding write");

  // Reset returns the scan to the map origin with no result pending.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && col_count == '0 && row_count == '0))
    else $error("scan state not cleared by reset");
`endif

endmodule

`default_nettype wire
